@@ sv/rps_pkg.sv @@
package rps_pkg;

  localparam int ADDR_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int PLEN_W         = 6;

  typedef struct packed {
    logic load;
    logic step;
  } rps_cmd_t;

  typedef struct packed {
    logic empty_rng;
    logic last;
    logic slot_free;
  } rps_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } rps_state_t;

endpackage

@@ sv/rps_if.sv @@
interface rps_in_if;
  logic                         valid;
  logic                         ready;
  logic [rps_pkg::FIELD_W-1:0]  lower_bound;
  logic [rps_pkg::FIELD_W-1:0]  upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface rps_out_if;
  logic                         valid;
  logic                         ready;
  logic [rps_pkg::FIELD_W-1:0]  prefix_base;
  logic [rps_pkg::PLEN_W-1:0]   prefix_length;
  logic                         last_prefix;

  modport source (output valid, output prefix_base, output prefix_length,
                  output last_prefix, input ready);
  modport sink   (input valid, input prefix_base, input prefix_length,
                  input last_prefix, output ready);
endinterface

@@ sv/rps_ctrl.sv @@
module rps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rps_pkg::rps_status_t status,
  output rps_pkg::rps_cmd_t    cmd
);

  rps_pkg::rps_state_t state_r, state_nxt;

  always_comb begin
    in_ready  = (state_r == rps_pkg::ST_IDLE);
    cmd.load  = in_valid && in_ready;
    cmd.step  = (state_r == rps_pkg::ST_RUN) && status.slot_free;
    state_nxt = state_r;
    unique case (state_r)
      rps_pkg::ST_IDLE: begin
        if (cmd.load && !status.empty_rng) state_nxt = rps_pkg::ST_RUN;
      end
      rps_pkg::ST_RUN: begin
        if (cmd.step && status.last) state_nxt = rps_pkg::ST_IDLE;
      end
      default: state_nxt = rps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !status.empty_rng) |=> state_r == rps_pkg::ST_RUN)
    else $error("nonempty range did not start a walk");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && status.empty_rng) |=> state_r == rps_pkg::ST_IDLE)
    else $error("empty range started a walk");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && status.last) |=> state_r == rps_pkg::ST_IDLE)
    else $error("walk continued past last prefix");

endmodule

@@ sv/rps_dp.sv @@
module rps_dp #(
  parameter int ADDR_WIDTH = rps_pkg::ADDR_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rps_pkg::FIELD_W-1:0]  lower_bound,
  input  logic [rps_pkg::FIELD_W-1:0]  upper_bound,
  input  rps_pkg::rps_cmd_t            cmd,
  output rps_pkg::rps_status_t         status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rps_pkg::FIELD_W-1:0]  prefix_base,
  output logic [rps_pkg::PLEN_W-1:0]   prefix_length,
  output logic                         last_prefix
);

  localparam int KW = $clog2(ADDR_WIDTH + 1);

  logic [ADDR_WIDTH-1:0]       lo_m, hi_m;
  logic [ADDR_WIDTH-1:0]       cur_r, cur_nxt;
  logic [ADDR_WIDTH:0]         len_r, len_nxt;
  logic [ADDR_WIDTH:0]         cur_ext, lowbit, lenmask, hibit, size, len_rem;
  logic [KW-1:0]               k;
  logic                        out_valid_r;
  logic [rps_pkg::FIELD_W-1:0] base_r;
  logic [rps_pkg::PLEN_W-1:0]  plen_r;
  logic                        last_r;

  always_comb begin
    lo_m    = lower_bound[ADDR_WIDTH-1:0];
    hi_m    = upper_bound[ADDR_WIDTH-1:0];
    cur_ext = {1'b1, cur_r};
    lowbit  = cur_ext & (~cur_ext + {{ADDR_WIDTH{1'b0}}, 1'b1});
    for (int i = 0; i <= ADDR_WIDTH; i++) begin
      lenmask[i] = |(len_r >> i);
    end
    hibit = lenmask & ~(lenmask >> 1);
    size  = (|(lowbit & lenmask)) ? lowbit : hibit;
    k     = '0;
    for (int i = 0; i <= ADDR_WIDTH; i++) begin
      if (size[i]) k = k | KW'(i);
    end
    len_rem = len_r - size;

    status.empty_rng = lo_m > hi_m;
    status.last      = (len_rem == '0);
    status.slot_free = !out_valid_r || out_ready;

    cur_nxt = cur_r;
    len_nxt = len_r;
    if (cmd.load) begin
      cur_nxt = lo_m;
      len_nxt = {1'b0, hi_m} - {1'b0, lo_m} + {{ADDR_WIDTH{1'b0}}, 1'b1};
    end else if (cmd.step) begin
      cur_nxt = cur_r + size[ADDR_WIDTH-1:0];
      len_nxt = len_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    len_r <= len_nxt;
    if (cmd.step) begin
      base_r <= rps_pkg::FIELD_W'(cur_r);
      plen_r <= rps_pkg::PLEN_W'(ADDR_WIDTH) - rps_pkg::PLEN_W'(k);
      last_r <= status.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign prefix_base   = base_r;
  assign prefix_length = plen_r;
  assign last_prefix   = last_r;

  a_size_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> $onehot(size))
    else $error("block size is not a single power of two");

  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid_r)
    else $error("prefix beat lost");

  a_len_left: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !status.last) |=> len_r != '0)
    else $error("range exhausted without last prefix");

endmodule

@@ sv/range_to_prefix_splitter.sv @@
// Range to prefix splitter.
// in_rng carries one inclusive address range per beat (lower_bound,
// upper_bound); bits at and above ADDR_WIDTH are ignored. out_pfx carries
// the covering aligned prefixes in ascending order, one per beat, with
// last_prefix set on the final one. A range with lower_bound above
// upper_bound is taken and gives no beats.
// Timing: an accepted range loads the running address and remaining length
// registers; each walk step then writes one prefix to the output register,
// one prefix per cycle while out_pfx is ready. Each prefix comes from one
// pass through the block-size logic on those two registers. A range gives
// at most 2*ADDR_WIDTH-2 prefixes (62 at the default width), and the next
// range is accepted in the cycle after the last prefix is produced.
// in_rng is ready only while no walk is running; the last prefix may still
// wait in the output register when the next range is taken.
// A stall on out_pfx holds the output beat and pauses the walk.
// Reset (rst_n low, synchronous) drops any walk in progress and any
// pending output beat.
module range_to_prefix_splitter #(
  parameter int ADDR_WIDTH = rps_pkg::ADDR_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  rps_in_if.sink in_rng,
  rps_out_if.source out_pfx
);

  rps_pkg::rps_cmd_t    cmd;
  rps_pkg::rps_status_t status;

  rps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rng.valid),
    .in_ready (in_rng.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rps_dp #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .lower_bound   (in_rng.lower_bound),
    .upper_bound   (in_rng.upper_bound),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_pfx.valid),
    .out_ready     (out_pfx.ready),
    .prefix_base   (out_pfx.prefix_base),
    .prefix_length (out_pfx.prefix_length),
    .last_prefix   (out_pfx.last_prefix)
  );

endmodule

@@ dv/tb_range_to_prefix_splitter.sv @@
`timescale 1ns / 100ps

module tb_range_to_prefix_splitter;

  localparam int AW = rps_pkg::ADDR_WIDTH_DEF;

  typedef struct {
    logic [rps_pkg::FIELD_W-1:0] base;
    logic [rps_pkg::PLEN_W-1:0]  length;
    logic                        last;
  } prefix_beat_t;

  class prefix_scoreboard;
    prefix_beat_t pending[$];
    int           errors = 0;

    function int pending_count();
      return pending.size();
    endfunction

    // greedy split of [lo, hi] into aligned blocks
    function void note_range(logic [rps_pkg::FIELD_W-1:0] lo,
                             logic [rps_pkg::FIELD_W-1:0] hi);
      longint unsigned amask, cur, top, nxt;
      int           k;
      int           cnt;
      bit           fin;
      prefix_beat_t pb;
      amask = (64'd1 << AW) - 1;
      cur   = lo & amask;
      top   = hi & amask;
      cnt   = 0;
      if (cur > top) return;
      while (cnt < 2 * AW - 2 || cnt == 0) begin
        k = 0;
        while (k < AW && ((cur >> k) & 64'd1) == 0 &&
               cur + ((64'd1 << (k + 1)) - 1) <= top)
          k++;
        nxt       = cur + (64'd1 << k);
        fin       = (nxt > top);
        pb.base   = cur[31:0];
        pb.length = 6'(AW - k);
        pb.last   = fin;
        pending.insert(pending.size(), pb);
        cnt++;
        if (fin) break;
        cur = nxt;
      end
    endfunction

    function void check_prefix(logic [rps_pkg::FIELD_W-1:0] base,
                               logic [rps_pkg::PLEN_W-1:0]  length,
                               logic                        last);
      prefix_beat_t exp_pb;
      if (pending.size() == 0) begin
        $display("%0t: unexpected prefix base=%h length=%0d last=%b",
                 $time, base, length, last);
        errors++;
        return;
      end
      exp_pb = pending.pop_front();
      if (base !== exp_pb.base) begin
        $display("%0t: prefix_base expected %h actual %h", $time, exp_pb.base, base);
        errors++;
      end
      if (length !== exp_pb.length) begin
        $display("%0t: prefix_length expected %0d actual %0d",
                 $time, exp_pb.length, length);
        errors++;
      end
      if (last !== exp_pb.last) begin
        $display("%0t: last_prefix expected %b actual %b", $time, exp_pb.last, last);
        errors++;
      end
    endfunction

    function void check_drained();
      if (pending.size() != 0) begin
        $display("%0t: %0d prefixes never arrived, next expected base=%h length=%0d",
                 $time, pending.size(), pending[0].base, pending[0].length);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rps_in_if  rng_if ();
  rps_out_if pfx_if ();

  range_to_prefix_splitter uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rng  (rng_if),
    .out_pfx (pfx_if)
  );

  prefix_scoreboard sb = new();

  bit src_idle  = 1'b0;
  bit sink_idle = 1'b0;
  int sink_hold = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      rng_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rng_if.valid       <= 1'b1;
    rng_if.lower_bound <= lo;
    rng_if.upper_bound <= hi;
    do @(posedge clk); while (!rng_if.ready);
    sb.note_range(lo, hi);
    @(negedge clk);
  endtask

  task automatic draw_range(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] span;
    case ($urandom_range(0, 5))
      0: begin
        lo = $urandom;
        hi = $urandom;
      end
      1: begin
        lo = $urandom;
        hi = lo + $urandom_range(0, 255);
      end
      2: begin
        lo = $urandom;
        span = (32'h1 << $urandom_range(0, 31)) - 1;
        hi = lo | span;
      end
      3: begin
        span = (32'h1 << $urandom_range(0, 31)) - 1;
        lo = $urandom & ~span;
        hi = lo + (span & $urandom);
      end
      4: begin
        lo = $urandom & ((32'h1 << $urandom_range(0, 31)) - 1);
        hi = ~($urandom & ((32'h1 << $urandom_range(0, 31)) - 1));
      end
      default: begin
        lo = $urandom;
        hi = lo;
      end
    endcase
  endtask

  initial begin
    int stall;
    pfx_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = sink_idle ? $urandom_range(0, 9) : 0;
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        pfx_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pfx_if.ready <= 1'b1;
      do @(posedge clk); while (!pfx_if.valid);
      sb.check_prefix(pfx_if.prefix_base, pfx_if.prefix_length, pfx_if.last_prefix);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    rst_n              <= 1'b0;
    rng_if.valid       <= 1'b0;
    rng_if.lower_bound <= '0;
    rng_if.upper_bound <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'hFFFF_FFFE);
    send_range(32'h0000_0005, 32'h0000_0004);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h8000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFE);
    send_range(32'h1234_5678, 32'h1234_5678);
    send_range(32'h0000_0010, 32'h0000_001F);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
    send_range(32'h0000_0000, 32'h0000_0001);
    send_range(32'h0000_0002, 32'h0000_0005);
    send_range(32'h7FFF_FFFF, 32'h8000_0000);
    send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);

    for (int seg = 0; seg < 4; seg++) begin
      src_idle  = (seg == 1) || (seg == 2);
      sink_idle = (seg == 1) || (seg == 3);
      repeat (110) begin
        draw_range(lo, hi);
        send_range(lo, hi);
      end
      if (seg == 1) begin
        // back up the output while ranges keep coming
        src_idle  = 1'b0;
        sink_hold = 400;
        repeat (12) begin
          lo = $urandom_range(0, 15);
          hi = ~($urandom & 32'h0000_FFFF);
          send_range(lo, hi);
        end
        rng_if.valid <= 1'b0;
        while (sb.pending_count() > 0) @(negedge clk);
      end
    end

    rng_if.valid <= 1'b0;
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (70) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/rps_pkg.sv
sv/rps_if.sv
sv/rps_ctrl.sv
sv/rps_dp.sv
sv/range_to_prefix_splitter.sv
dv/tb_range_to_prefix_splitter.sv
